FILE: sv/tlpte_pkg.sv
// Shared types and constants for the two-level page table engine.
package tlpte_pkg;

    localparam int DIR_BITS     = 10;
    localparam int PT_BITS      = 10;
    localparam int OFS_BITS     = 12;
    localparam int DIR_ENTRIES  = 1 << DIR_BITS;
    localparam int PT_ENTRIES   = 1 << PT_BITS;
    localparam int FRAME_BITS   = 32 - OFS_BITS;
    localparam int FLAG_PRESENT = 0;
    localparam int FLAG_USER    = 2;

    typedef enum logic [1:0] {
        MODE_MAP   = 2'd0,
        MODE_UNMAP = 2'd1,
        MODE_XLATE = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_DONE       = 2'd0,
        STAT_NO_TABLES  = 2'd1,
        STAT_NOT_MAPPED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_PT
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [31:0] result_addr;
        logic        tlb_invalidate;
    } t_rsp;

endpackage

FILE: sv/tlpte_ifs.sv
// Request and response channel interfaces of the page table engine.
interface tlpte_req_if;
    import tlpte_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [11:0] page_flags;

    modport source (output valid, mode, virt_addr, phys_addr, page_flags, input ready);
    modport sink   (input valid, mode, virt_addr, phys_addr, page_flags, output ready);
endinterface

interface tlpte_rsp_if;
    import tlpte_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] result_addr;
    logic        tlb_invalidate;

    modport source (output valid, status, result_addr, tlb_invalidate, input ready);
    modport sink   (input valid, status, result_addr, tlb_invalidate, output ready);
endinterface

FILE: sv/tlpte_out_reg.sv
// Response output register: holds one result until its transfer completes.
module tlpte_out_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  tlpte_pkg::t_rsp i_data,
    output logic            o_free,
    tlpte_rsp_if.source     o_rsp
);
    import tlpte_pkg::*;

    logic r_valid;
    logic n_valid;
    t_rsp r_data;

    always_comb begin
        o_free = !r_valid || o_rsp.ready;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.status         = r_data.status;
    assign o_rsp.result_addr    = r_data.result_addr;
    assign o_rsp.tlb_invalidate = r_data.tlb_invalidate;

endmodule

FILE: sv/two_level_page_table_engine_unit.sv
// Two-level page table engine: map, unmap and translate over a 10/10/12 split.
// After reset the block runs a clearing pass over all TABLES*1024 entries of the
// page table store (the directory is cleared in the same pass) and takes no
// request until it ends. A map, a no-op, or an unmap or translate whose
// directory entry is absent goes through S_IDLE, which issues the directory
// read, and S_DIR, which uses the directory entry; an unmap or translate that
// reaches a page table goes on to S_PT, which uses the page table entry.
// Both stores are single-port synchronous memories; only one request is in
// work at a time, so a write always lands before the next read. The result
// is held in an output register, so a new request is taken while it waits;
// that request then stalls in the engine until the register frees.
module two_level_page_table_engine_unit #(
    parameter int TABLES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlpte_req_if.sink   i_req,
    tlpte_rsp_if.source o_rsp
);
    import tlpte_pkg::*;

    localparam int TW          = (TABLES > 1) ? $clog2(TABLES) : 1;
    localparam int UW          = $clog2(TABLES + 1);
    localparam int SW          = TW + PT_BITS;
    localparam int DW          = TW + 2;
    localparam int STORE_DEPTH = TABLES * PT_ENTRIES;

    t_state          r_state, n_state;
    logic [SW-1:0]   r_clr, n_clr;
    logic [UW-1:0]   r_used, n_used;

    t_mode           r_mode;
    logic [31:0]     r_va;
    logic [FRAME_BITS-1:0] r_frame;
    logic [11:0]     r_fl;
    logic [SW-1:0]   r_slot;

    logic [DW-1:0]   dir_mem [0:DIR_ENTRIES-1];
    logic [DW-1:0]   r_dir_q;
    logic [31:0]     pt_mem [0:STORE_DEPTH-1];
    logic [31:0]     r_pt_q;

    logic                dir_we, dir_re;
    logic [DIR_BITS-1:0] dir_waddr, dir_raddr;
    logic [DW-1:0]       dir_wdata;
    logic                pt_we, pt_re;
    logic [SW-1:0]       pt_waddr, pt_raddr;
    logic [31:0]         pt_wdata;

    logic          req_fire;
    logic          out_free, out_load;
    t_rsp          out_data;
    logic          dir_present;
    logic [TW-1:0] dir_table;
    logic [TW-1:0] tbl_sel;
    logic [PT_BITS-1:0] pt_idx;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign dir_present = r_dir_q[DW-1];
    assign dir_table   = r_dir_q[TW-1:0];
    assign pt_idx      = r_va[OFS_BITS +: PT_BITS];

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_used    = r_used;
        dir_we    = 1'b0;
        dir_waddr = r_va[31 -: DIR_BITS];
        dir_wdata = '0;
        dir_re    = 1'b0;
        dir_raddr = i_req.virt_addr[31 -: DIR_BITS];
        pt_we     = 1'b0;
        pt_waddr  = r_slot;
        pt_wdata  = '0;
        pt_re     = 1'b0;
        pt_raddr  = {dir_table, pt_idx};
        tbl_sel   = dir_present ? dir_table : r_used[TW-1:0];
        out_load  = 1'b0;
        out_data  = '{status: STAT_DONE, result_addr: 32'd0, tlb_invalidate: 1'b0};

        case (r_state)
            S_CLEAR: begin
                dir_we    = 1'b1;
                dir_waddr = r_clr[DIR_BITS-1:0];
                pt_we     = 1'b1;
                pt_waddr  = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == SW'(STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    dir_re  = 1'b1;
                    n_state = S_DIR;
                end
            end
            S_DIR: begin
                if (out_free) begin
                    case (r_mode)
                        MODE_MAP: begin
                            out_load = 1'b1;
                            n_state  = S_IDLE;
                            if (!dir_present && (r_used >= UW'(TABLES))) begin
                                out_data.status = STAT_NO_TABLES;
                            end else begin
                                if (!dir_present) begin
                                    dir_we    = 1'b1;
                                    dir_wdata = {1'b1, r_fl[FLAG_USER], r_used[TW-1:0]};
                                    n_used    = r_used + 1'b1;
                                end
                                pt_we    = 1'b1;
                                pt_waddr = {tbl_sel, pt_idx};
                                pt_wdata = {r_frame, r_fl | 12'h001};
                                out_data.tlb_invalidate = 1'b1;
                            end
                        end
                        MODE_UNMAP, MODE_XLATE: begin
                            if (!dir_present) begin
                                out_load        = 1'b1;
                                out_data.status = STAT_NOT_MAPPED;
                                n_state         = S_IDLE;
                            end else begin
                                pt_re   = 1'b1;
                                n_state = S_PT;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                            n_state  = S_IDLE;
                        end
                    endcase
                end
            end
            S_PT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    if (!r_pt_q[FLAG_PRESENT]) begin
                        out_data.status = STAT_NOT_MAPPED;
                    end else if (r_mode == MODE_UNMAP) begin
                        out_data.result_addr    = {r_pt_q[31 -: FRAME_BITS], 12'h000};
                        out_data.tlb_invalidate = 1'b1;
                        pt_we                   = 1'b1;
                    end else begin
                        out_data.result_addr = {r_pt_q[31 -: FRAME_BITS],
                                                r_va[OFS_BITS-1:0]};
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_mode  <= t_mode'(i_req.mode);
            r_va    <= i_req.virt_addr;
            r_frame <= i_req.phys_addr[31 -: FRAME_BITS];
            r_fl    <= i_req.page_flags;
        end
        if (pt_re) begin
            r_slot <= pt_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (dir_re) begin
            r_dir_q <= dir_mem[dir_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        if (pt_re) begin
            r_pt_q <= pt_mem[pt_raddr];
        end
    end

    tlpte_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_data  (out_data),
        .o_free  (out_free),
        .o_rsp   (o_rsp)
    );

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> !i_req.ready)
        else $error("request taken while another is in work");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result loaded over a pending result");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(TABLES))
        else $error("table pool count beyond pool size");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIR && dir_we) |=> (r_used == $past(r_used) + 1'b1))
        else $error("table allocation without count increment");

    a_inval_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.tlb_invalidate) |-> (o_rsp.status == STAT_DONE))
        else $error("flush request on failed operation");

endmodule
